@@ src/tecu_pkg.sv @@
// ----------------------------------------------------------------------------
// tecu_pkg
// Shared types and constants of the terminal escape cursor engine: render
// command codes, the result item layout, the configuration bundle and the
// size of the result queue.
// ----------------------------------------------------------------------------
package tecu_pkg;

  localparam int POS_W  = 16;
  localparam int CMD_W  = 4;
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_DRAW         = 4'd0;
  localparam logic [CMD_W-1:0] CMD_SCROLL_UP    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SCROLL_DOWN  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR_RIGHT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR_LEFT   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR_LINE   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR_DOWN   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_CLEAR_UP     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_CLEAR_SCREEN = 4'd8;

  // Configuration register indexes (word address bits).
  localparam logic [1:0] REG_SCREEN_W = 2'd0;
  localparam logic [1:0] REG_SCREEN_H = 2'd1;
  localparam logic [1:0] REG_CELL_W   = 2'd2;
  localparam logic [1:0] REG_CELL_H   = 2'd3;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  typedef struct packed {
    logic [12:0] screen_w;
    logic [12:0] screen_h;
    logic [5:0]  cell_w;
    logic [5:0]  cell_h;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] glyph;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic              final_res;
  } res_t;

  // Zero, one or two result items produced by one input item.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

@@ src/tecu_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tecu_cfg_regs
// APB-style register file holding screen and character cell dimensions.
// ----------------------------------------------------------------------------
module tecu_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tecu_pkg::ADDR_W-1:0] paddr,
  input  logic [tecu_pkg::DATA_W-1:0] pwdata,
  output logic [tecu_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output tecu_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_w <= 13'd640;
      cfg.screen_h <= 13'd480;
      cfg.cell_w   <= 6'd8;
      cfg.cell_h   <= 6'd16;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tecu_pkg::REG_SCREEN_W: cfg.screen_w <= pwdata[12:0];
        tecu_pkg::REG_SCREEN_H: cfg.screen_h <= pwdata[12:0];
        tecu_pkg::REG_CELL_W:   cfg.cell_w   <= pwdata[5:0];
        tecu_pkg::REG_CELL_H:   cfg.cell_h   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tecu_pkg::REG_SCREEN_W: prdata = {19'd0, cfg.screen_w};
      tecu_pkg::REG_SCREEN_H: prdata = {19'd0, cfg.screen_h};
      tecu_pkg::REG_CELL_W:   prdata = {26'd0, cfg.cell_w};
      tecu_pkg::REG_CELL_H:   prdata = {26'd0, cfg.cell_h};
      default:                prdata = '0;
    endcase
  end

endmodule

@@ src/tecu_parser.sv @@
// ----------------------------------------------------------------------------
// tecu_parser
// Input register, escape sequence parser and cursor update. One byte per cycle
// is decoded while the result queue has room; its items are pushed into it.
// ----------------------------------------------------------------------------
module tecu_parser #(
  parameter int NUMBER_BITS = 8,
  parameter int COORD_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [tecu_pkg::BYTE_W-1:0] data_byte,
  input  tecu_pkg::cfg_t              cfg,
  input  logic                        room,
  output tecu_pkg::push_t             push
);

  localparam int NB = NUMBER_BITS;
  localparam int C  = COORD_BITS;
  localparam int MW = NB + 6;
  localparam int XW = (C > MW) ? C : MW;
  localparam int SW = ((C > 13) ? C : 13) + 2;
  localparam int AW = NB + 4;

  localparam logic [7:0] CH_BEL   = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POUND = 8'h23;
  localparam logic [7:0] CH_OPAR  = 8'h28;
  localparam logic [7:0] CH_CPAR  = 8'h29;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_F  = 8'h66;

  typedef enum logic [3:0] {
    ST_TEXT, ST_ESC, ST_CSI, ST_OPAREN, ST_CPAREN, ST_POUND, ST_FIVE, ST_SIX,
    ST_NUM, ST_NUM_SEMI, ST_NUM_SEMI_NUM, ST_QUEST, ST_QUEST_NUM, ST_SEMI
  } state_t;

  state_t          parse_state, parse_state_next;
  logic            stage_valid;
  logic [7:0]      byte_q;
  logic [NB-1:0]   first_number, first_number_next;
  logic [NB-1:0]   second_number, second_number_next;
  logic [C-1:0]    cur_x, cur_x_next, cur_y, cur_y_next;
  logic [C-1:0]    saved_x, saved_x_next, saved_y, saved_y_next;

  logic            accept, fire;
  logic            is_digit;
  logic [NB-1:0]   digit;
  logic [C-1:0]    cw, ch;
  logic [XW-1:0]   prod_x, prod_y;
  logic [C-1:0]    mx, my;
  logic [AW-1:0]   acc_first, acc_second;
  logic [NB-1:0]   sat_first, sat_second;
  logic [C-1:0]    x_adv, x_txt, y_txt, y_scr;
  logic            wrap, newline, scroll;
  logic [SW-1:0]   lim_x, lim_y;

  assign accept     = data_valid && !data_stall;
  assign fire       = stage_valid && room;
  assign data_stall = stage_valid && !room;

  assign is_digit = (byte_q >= CH_0) && (byte_q <= CH_9);
  assign digit    = NB'(byte_q[3:0]);
  assign cw       = C'(cfg.cell_w);
  assign ch       = C'(cfg.cell_h);

  // One product for each axis; x uses the second parameter in the
  // row/column positioning state and the first one for relative moves.
  assign prod_x = XW'(cfg.cell_w) *
                  XW'((parse_state == ST_NUM_SEMI_NUM) ? second_number : first_number);
  assign prod_y = XW'(cfg.cell_h) * XW'(first_number);
  assign mx     = prod_x[C-1:0];
  assign my     = prod_y[C-1:0];

  // Decimal accumulation n*10+d, saturating at all ones.
  assign acc_first  = {first_number, 3'b000} + {3'b000, first_number, 1'b0}
                      + AW'(byte_q[3:0]);
  assign acc_second = {second_number, 3'b000} + {3'b000, second_number, 1'b0}
                      + AW'(byte_q[3:0]);
  assign sat_first  = (acc_first[AW-1:NB] != '0) ? {NB{1'b1}} : acc_first[NB-1:0];
  assign sat_second = (acc_second[AW-1:NB] != '0) ? {NB{1'b1}} : acc_second[NB-1:0];

  // Text path: advance, wrap at the right margin, scroll at the bottom.
  assign lim_x   = SW'(cfg.screen_w) - SW'(cfg.cell_w);
  assign lim_y   = SW'(cfg.screen_h) - SW'(cfg.cell_h);
  assign x_adv   = cur_x + cw;
  assign newline = (byte_q == CH_LF);
  assign wrap    = ($signed(SW'(x_adv)) >= $signed(lim_x)) || newline;
  assign x_txt   = wrap ? '0 : x_adv;
  assign y_txt   = wrap ? (cur_y + ch) : cur_y;
  assign scroll  = $signed(SW'(y_txt)) > $signed(lim_y);
  assign y_scr   = y_txt - ch;

  always_comb begin
    parse_state_next   = ST_TEXT;
    first_number_next  = first_number;
    second_number_next = second_number;
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    saved_x_next       = saved_x;
    saved_y_next       = saved_y;
    push.n             = 2'd0;
    push.r0.command    = tecu_pkg::CMD_DRAW;
    push.r0.glyph      = '0;
    push.r0.pos_x      = tecu_pkg::POS_W'(cur_x);
    push.r0.pos_y      = tecu_pkg::POS_W'(cur_y);
    push.r0.final_res  = 1'b1;
    push.r1.command    = tecu_pkg::CMD_SCROLL_UP;
    push.r1.glyph      = '0;
    push.r1.pos_x      = tecu_pkg::POS_W'(x_txt);
    push.r1.pos_y      = tecu_pkg::POS_W'(y_txt);
    push.r1.final_res  = 1'b1;

    unique case (parse_state)
      ST_TEXT: begin
        if (byte_q == CH_ESC) begin
          parse_state_next = ST_ESC;
        end else begin
          push.n        = 2'd1;
          push.r0.glyph = (newline || byte_q == CH_CR || byte_q == CH_BS ||
                           byte_q == CH_BEL) ? CH_SPACE : byte_q;
          if (byte_q == CH_BS) begin
            cur_x_next = cur_x - cw;
          end else if (byte_q != CH_BEL) begin
            cur_x_next = x_txt;
            cur_y_next = y_txt;
            if (scroll) begin
              push.n            = 2'd2;
              push.r0.final_res = 1'b0;
              cur_y_next        = y_scr;
            end
          end
        end
      end
      ST_ESC: begin
        case (byte_q)
          CH_LBRK: parse_state_next = ST_CSI;
          CH_OPAR: parse_state_next = ST_OPAREN;
          CH_CPAR: parse_state_next = ST_CPAREN;
          CH_POUND: parse_state_next = ST_POUND;
          CH_5:    parse_state_next = ST_FIVE;
          CH_6:    parse_state_next = ST_SIX;
          CH_D, CH_E: begin
            push.n          = 2'd1;
            push.r0.command = tecu_pkg::CMD_SCROLL_UP;
            cur_y_next      = cur_y - ch;
          end
          CH_M: begin
            push.n          = 2'd1;
            push.r0.command = tecu_pkg::CMD_SCROLL_DOWN;
          end
          CH_7: begin
            saved_x_next = cur_x;
            saved_y_next = cur_y;
          end
          CH_8: begin
            cur_x_next = saved_x;
            cur_y_next = saved_y;
          end
          CH_LC_C: begin
            push.n          = 2'd1;
            push.r0.command = tecu_pkg::CMD_CLEAR_SCREEN;
            cur_x_next      = '0;
            cur_y_next      = '0;
            saved_x_next    = '0;
            saved_y_next    = '0;
          end
          default: ;
        endcase
      end
      ST_CSI: begin
        if (byte_q == CH_QUEST) begin
          parse_state_next = ST_QUEST;
        end else if (byte_q == CH_SEMI) begin
          parse_state_next = ST_SEMI;
        end else if (byte_q == CH_H || byte_q == CH_LC_F) begin
          cur_x_next = '0;
          cur_y_next = '0;
        end else if (byte_q == CH_K) begin
          push.n          = 2'd1;
          push.r0.command = tecu_pkg::CMD_CLEAR_RIGHT;
        end else if (byte_q == CH_J) begin
          push.n          = 2'd1;
          push.r0.command = tecu_pkg::CMD_CLEAR_DOWN;
        end else if (is_digit) begin
          first_number_next = digit;
          parse_state_next  = ST_NUM;
        end
      end
      ST_NUM: begin
        if (byte_q == CH_SEMI) begin
          parse_state_next = ST_NUM_SEMI;
        end else if (byte_q == CH_A) begin
          cur_y_next = cur_y - my;
        end else if (byte_q == CH_B) begin
          cur_y_next = cur_y + my;
        end else if (byte_q == CH_C) begin
          cur_x_next = cur_x + mx;
        end else if (byte_q == CH_D) begin
          cur_x_next = cur_x - mx;
        end else if (byte_q == CH_K || byte_q == CH_J) begin
          // Parameters above two select nothing.
          if (first_number <= NB'(2)) begin
            push.n          = 2'd1;
            push.r0.command = ((byte_q == CH_K) ? tecu_pkg::CMD_CLEAR_RIGHT
                                                : tecu_pkg::CMD_CLEAR_DOWN)
                              + tecu_pkg::CMD_W'(first_number[1:0]);
          end
        end else if (is_digit) begin
          first_number_next = sat_first;
          parse_state_next  = ST_NUM;
        end
      end
      ST_NUM_SEMI: begin
        if (is_digit) begin
          second_number_next = digit;
          parse_state_next   = ST_NUM_SEMI_NUM;
        end
      end
      ST_NUM_SEMI_NUM: begin
        if (byte_q == CH_H || byte_q == CH_LC_F) begin
          // Row and column count from one; a zero wraps below the origin.
          cur_x_next = mx - cw;
          cur_y_next = my - ch;
        end else if (is_digit) begin
          second_number_next = sat_second;
          parse_state_next   = ST_NUM_SEMI_NUM;
        end
      end
      ST_QUEST: begin
        if (byte_q >= CH_1 && byte_q <= CH_9) begin
          first_number_next = digit;
          parse_state_next  = ST_QUEST_NUM;
        end
      end
      ST_SEMI: begin
        if (byte_q == CH_H || byte_q == CH_LC_F) begin
          cur_x_next = '0;
          cur_y_next = '0;
        end
      end
      default: ;
    endcase

    if (!fire) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      parse_state   <= ST_TEXT;
      first_number  <= '0;
      second_number <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      saved_x       <= '0;
      saved_y       <= '0;
    end else begin
      if (accept) begin
        stage_valid <= 1'b1;
      end else if (fire) begin
        stage_valid <= 1'b0;
      end
      if (fire) begin
        parse_state   <= parse_state_next;
        first_number  <= first_number_next;
        second_number <= second_number_next;
        cur_x         <= cur_x_next;
        cur_y         <= cur_y_next;
        saved_x       <= saved_x_next;
        saved_y       <= saved_y_next;
      end
    end
    if (accept) begin
      byte_q <= data_byte;
    end
  end

  a_pair_is_draw_then_scroll: assert property (@(posedge clk) disable iff (rst)
    push.n == 2'd2 |-> push.r0.command == tecu_pkg::CMD_DRAW &&
                       push.r1.command == tecu_pkg::CMD_SCROLL_UP &&
                       !push.r0.final_res && push.r1.final_res)
    else $error("two-item push is not a draw followed by a scroll");

  a_push_needs_item: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> stage_valid && room)
    else $error("result pushed without a decoded item");

  a_escape_is_silent: assert property (@(posedge clk) disable iff (rst)
    fire && parse_state == ST_TEXT && byte_q == CH_ESC |=> parse_state == ST_ESC)
    else $error("escape byte did not enter the escape state");

endmodule

@@ src/tecu_out_fifo.sv @@
// ----------------------------------------------------------------------------
// tecu_out_fifo
// Small result queue that takes up to two items per cycle and hands out one
// item per cycle on the result channel while result_stall is low.
// ----------------------------------------------------------------------------
module tecu_out_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  tecu_pkg::push_t                  push,
  output logic                             room,
  output logic                             result_valid,
  input  logic                             result_stall,
  output tecu_pkg::res_t                   head
);

  tecu_pkg::res_t                 mem [tecu_pkg::FIFO_DEPTH];
  logic [tecu_pkg::PTR_W-1:0]     wr_ptr, rd_ptr;
  logic [tecu_pkg::CNT_W-1:0]     count;
  logic                           pop;
  logic [tecu_pkg::PTR_W-1:0]     wr_ptr_1;

  assign result_valid = (count != '0);
  assign pop          = result_valid && !result_stall;
  assign head         = mem[rd_ptr];
  assign wr_ptr_1     = wr_ptr + tecu_pkg::PTR_W'(1);
  // Space for a full pair of items, judged on the registered fill level.
  assign room = (count <= tecu_pkg::CNT_W'(tecu_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tecu_pkg::PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + tecu_pkg::PTR_W'(1);
      end
      count <= count + tecu_pkg::CNT_W'(push.n) - tecu_pkg::CNT_W'(pop);
    end
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr_1] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= tecu_pkg::CNT_W'(tecu_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_pair_fits: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 |-> count <= tecu_pkg::CNT_W'(tecu_pkg::FIFO_DEPTH - 2))
    else $error("push into a queue without room for two items");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push.n != 2'd0 && !pop |=> result_valid)
    else $error("pushed item not visible on the result channel");

endmodule

@@ src/terminal_escape_cursor_engine_unit.sv @@
// ----------------------------------------------------------------------------
// terminal_escape_cursor_engine_unit
// VT100-style escape parser and pixel cursor engine that turns a byte stream
// into draw, scroll and clear commands.
// ----------------------------------------------------------------------------
// Pipeline: an accepted byte is held in the input register and decoded when
// the result queue has room, and its items are queued for the result channel.
// Throughput: one byte per cycle while the queue has room, one result item per
// cycle unless stalled; a byte that draws and scrolls fills two of four entries.
// Reset: synchronous; parser state, cursor, saved cursor and queue clear, and
// the registers return to a 640 by 480 screen with 8 by 16 cells.
module terminal_escape_cursor_engine_unit #(
  parameter int NUMBER_BITS = 8,
  parameter int COORD_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tecu_pkg::ADDR_W-1:0] paddr,
  input  logic [tecu_pkg::DATA_W-1:0] pwdata,
  output logic [tecu_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [7:0]                  data_byte,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [3:0]                  command,
  output logic [7:0]                  glyph,
  output logic [15:0]                 pos_x,
  output logic [15:0]                 pos_y,
  output logic                        final_res
);

  tecu_pkg::cfg_t  cfg;
  tecu_pkg::push_t push;
  tecu_pkg::res_t  head;
  logic            room;

  tecu_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tecu_parser #(
    .NUMBER_BITS (NUMBER_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .cfg        (cfg),
    .room       (room),
    .push       (push)
  );

  tecu_out_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign command   = head.command;
  assign glyph     = head.glyph;
  assign pos_x     = head.pos_x;
  assign pos_y     = head.pos_y;
  assign final_res = head.final_res;

endmodule
